// ----- sv/rsor_pkg.sv -----
// rsor_pkg: shared types and constants of the range sigma outlier reject block.
// No dependencies; fifo, front, back and top refer to it by scoped names; the test files import it.
`default_nettype none
package rsor_pkg;

    localparam int MaxPoints = 64;
    localparam int CoordW    = 24;
    localparam int DiffW     = CoordW + 1;
    localparam int DistW     = 25;
    localparam int SqW       = 2 * DiffW;
    localparam int MultW     = 12;
    localparam int OutIdxW   = 6;
    localparam int FifoDepth = 4;
    localparam int FracBits  = 8;

    localparam logic       CfgIdxRejectEnable = 1'b0;
    localparam logic       CfgIdxSigmaMult    = 1'b1;
    localparam logic [MultW-1:0] SigmaMultReset = 12'd384;

    // one distance word moved from the front end to the back end
    typedef struct packed {
        logic [DistW-1:0] distance;
        logic             eos;
    } t_dist_word;

    // live configuration seen by the back end
    typedef struct packed {
        logic             reject_en;
        logic [MultW-1:0] sigma_mult;
    } t_cfg;

    typedef enum logic [2:0] {
        F_IDLE,
        F_SQ,
        F_ADD,
        F_ROOT,
        F_PUSH
    } t_front_state;

    typedef enum logic [4:0] {
        B_IDLE,
        B_SUM_RD,
        B_SUM_AC,
        B_MEAN_GO,
        B_MEAN_WT,
        B_VAR_RD,
        B_VAR_DF,
        B_VAR_MUL,
        B_VAR_AC,
        B_DVAR_GO,
        B_DVAR_WT,
        B_ROOT_GO,
        B_ROOT_WT,
        B_LIM,
        B_OUT_RD,
        B_OUT_CMP,
        B_OUT_WT
    } t_back_state;

endpackage
`default_nettype wire

// ----- sv/rsor_ram.sv -----
// rsor_ram: generic single write port, single read port RAM, registered read.
// No dependencies.
`default_nettype none
module rsor_ram #(
    parameter int WIDTH = 25,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// ----- sv/rsor_isqrt.sv -----
// rsor_isqrt: iterative integer square root, one result bit per cycle.
// No dependencies. Result is floor(sqrt(value)); W must be even.
`default_nettype none
module rsor_isqrt #(
    parameter int W = 50
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [W-1:0]     i_value,
    output logic                  o_done,
    output logic      [W/2-1:0]   o_root
);
    localparam int N  = W / 2;
    localparam int CW = $clog2(N + 1);

    logic          r_busy;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_val;
    logic [N:0]    r_rem;
    logic [N-1:0]  r_root;
    logic          r_done;
    logic [N+2:0]  rem_sh;
    logic [N+2:0]  trial;
    logic [N:0]    n_rem;
    logic [N-1:0]  n_root;

    // one digit step: bring down two bits, try root*4+1
    always_comb begin
        rem_sh = {r_rem, r_val[W-1:W-2]};
        trial  = {1'b0, r_root, 2'b01};
        if (rem_sh >= trial) begin
            n_rem  = (N+1)'(rem_sh - trial);
            n_root = {r_root[N-2:0], 1'b1};
        end else begin
            n_rem  = rem_sh[N:0];
            n_root = {r_root[N-2:0], 1'b0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_val  <= i_value;
                r_rem  <= '0;
                r_root <= '0;
            end else if (r_busy) begin
                r_val  <= {r_val[W-3:0], 2'b00};
                r_rem  <= n_rem;
                r_root <= n_root;
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CW'(N - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_root = r_root;
endmodule
`default_nettype wire

// ----- sv/rsor_div.sv -----
// rsor_div: restoring divider, one quotient bit per cycle.
// No dependencies. Divisor must be nonzero.
`default_nettype none
module rsor_div #(
    parameter int W  = 56,
    parameter int DW = 7
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire logic [W-1:0]  i_dividend,
    input  wire logic [DW-1:0] i_divisor,
    output logic               o_done,
    output logic      [W-1:0]  o_quo
);
    localparam int CW = $clog2(W + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic [W-1:0]  r_quo;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dsr;
    logic [DW:0]   rem_sh;
    logic [DW-1:0] n_rem;
    logic          q_bit;

    // shift in next dividend bit, subtract if it fits
    always_comb begin
        rem_sh = {r_rem, r_quo[W-1]};
        if (rem_sh >= {1'b0, r_dsr}) begin
            n_rem = DW'(rem_sh - {1'b0, r_dsr});
            q_bit = 1'b1;
        end else begin
            n_rem = rem_sh[DW-1:0];
            q_bit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_quo  <= i_dividend;
                r_rem  <= '0;
                r_dsr  <= i_divisor;
            end else if (r_busy) begin
                r_quo <= {r_quo[W-2:0], q_bit};
                r_rem <= n_rem;
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CW'(W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

// ----- sv/rsor_fifo.sv -----
// rsor_fifo: short queue of distance words between front and back end.
// Depends on rsor_pkg.
`default_nettype none
module rsor_fifo (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_push_valid,
    output logic                    o_push_ready,
    input  wire rsor_pkg::t_dist_word i_push_word,
    output logic                    o_pop_valid,
    input  wire logic               i_pop_ready,
    output rsor_pkg::t_dist_word    o_pop_word
);
    localparam int Depth = rsor_pkg::FifoDepth;
    localparam int PW    = $clog2(Depth);
    localparam int CW    = $clog2(Depth + 1);

    rsor_pkg::t_dist_word r_buf [Depth];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    logic          push;
    logic          pop;

    assign o_push_ready = (r_cnt != CW'(Depth));
    assign o_pop_valid  = (r_cnt != '0);
    assign o_pop_word   = r_buf[r_rd];
    assign push = i_push_valid && o_push_ready;
    assign pop  = o_pop_valid && i_pop_ready;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_buf[r_wr] <= i_push_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) r_wr <= r_wr + 1'b1;
            if (pop)  r_rd <= r_rd + 1'b1;
            if (push && !pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop && !push) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end
endmodule
`default_nettype wire

// ----- sv/rsor_front.sv -----
// rsor_front: takes point pairs, computes the integer (Q25.0) distance isqrt(dx^2+dy^2).
// Depends on rsor_pkg and rsor_isqrt.
`default_nettype none
module rsor_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_valid,
    output logic                              o_ready,
    input  wire logic [rsor_pkg::CoordW-1:0]  i_p_x,
    input  wire logic [rsor_pkg::CoordW-1:0]  i_p_y,
    input  wire logic [rsor_pkg::CoordW-1:0]  i_q_x,
    input  wire logic [rsor_pkg::CoordW-1:0]  i_q_y,
    input  wire logic                         i_end_of_set,
    output logic                              o_push_valid,
    input  wire logic                         i_push_ready,
    output rsor_pkg::t_dist_word              o_push_word
);
    localparam int DiffW = rsor_pkg::DiffW;
    localparam int SqW   = rsor_pkg::SqW;

    rsor_pkg::t_front_state r_state, n_state;
    logic signed [DiffW-1:0] r_dx, r_dy;
    logic [SqW-1:0] r_sqx, r_sqy;
    logic [rsor_pkg::DistW-1:0] r_dist;
    logic r_eos;
    logic [DiffW-1:0] ax, ay;
    logic root_start, root_done;
    logic [SqW/2-1:0] root;
    logic [SqW-1:0] sq_sum;

    assign ax     = r_dx[DiffW-1] ? DiffW'(-r_dx) : DiffW'(r_dx);
    assign ay     = r_dy[DiffW-1] ? DiffW'(-r_dy) : DiffW'(r_dy);
    assign sq_sum = r_sqx + r_sqy;

    rsor_isqrt #(.W(SqW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (sq_sum),
        .o_done  (root_done),
        .o_root  (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsor_pkg::F_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == rsor_pkg::F_IDLE && i_valid) begin
            r_dx  <= DiffW'($signed(i_p_x)) - DiffW'($signed(i_q_x));
            r_dy  <= DiffW'($signed(i_p_y)) - DiffW'($signed(i_q_y));
            r_eos <= i_end_of_set;
        end
        if (r_state == rsor_pkg::F_SQ) begin
            r_sqx <= ax * ax;
            r_sqy <= ay * ay;
        end
        if (r_state == rsor_pkg::F_ROOT && root_done) begin
            r_dist <= rsor_pkg::DistW'(root);
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        o_ready      = 1'b0;
        o_push_valid = 1'b0;
        root_start   = 1'b0;
        unique case (r_state)
            rsor_pkg::F_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) n_state = rsor_pkg::F_SQ;
            end
            rsor_pkg::F_SQ:  n_state = rsor_pkg::F_ADD;
            rsor_pkg::F_ADD: begin
                root_start = 1'b1;
                n_state    = rsor_pkg::F_ROOT;
            end
            rsor_pkg::F_ROOT: begin
                if (root_done) n_state = rsor_pkg::F_PUSH;
            end
            rsor_pkg::F_PUSH: begin
                o_push_valid = 1'b1;
                if (i_push_ready) n_state = rsor_pkg::F_IDLE;
            end
            default: n_state = rsor_pkg::F_IDLE;
        endcase
    end

    assign o_push_word.distance = r_dist;
    assign o_push_word.eos      = r_eos;
endmodule
`default_nettype wire

// ----- sv/rsor_back.sv -----
// rsor_back: stores distances, computes mean and sigma, emits keep words.
// Depends on rsor_pkg, rsor_ram, rsor_div and rsor_isqrt.
`default_nettype none
module rsor_back #(
    parameter int MAX_POINTS = rsor_pkg::MaxPoints
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire rsor_pkg::t_cfg                i_cfg,
    input  wire logic                          i_pop_valid,
    output logic                               o_pop_ready,
    input  wire rsor_pkg::t_dist_word          i_pop_word,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [rsor_pkg::OutIdxW-1:0]       o_pair_index,
    output logic                               o_keep,
    output logic                               o_last_result
);
    localparam int DistW = rsor_pkg::DistW;
    localparam int AW    = $clog2(MAX_POINTS);
    localparam int CntW  = $clog2(MAX_POINTS + 1);
    localparam int SumW  = DistW + CntW;
    localparam int VarW  = 2 * DistW + AW + (AW % 2);
    localparam int SigW  = VarW / 2;
    localparam int LimW  = rsor_pkg::MultW + SigW + 1;
    localparam int FB    = rsor_pkg::FracBits;

    rsor_pkg::t_back_state r_state, n_state;
    logic [CntW-1:0]  r_cnt;
    logic [AW-1:0]    r_idx;
    logic [SumW-1:0]  r_sum;
    logic [DistW-1:0] r_mean;
    logic [DistW-1:0] r_df;
    logic [2*DistW-1:0] r_prod;
    logic [VarW-1:0]  r_sq;
    logic [SigW-1:0]  r_sigma;
    logic [LimW-1:0]  r_lim;
    logic             r_keep;
    logic             r_last;
    logic             r_valid;
    logic [DistW-1:0] rdata;
    logic             we;
    logic             at_end;
    logic             div_start, div_done, root_start, root_done;
    logic [VarW-1:0]  div_dividend, div_quo;
    logic [CntW-1:0]  div_divisor;
    logic [SigW-1:0]  root;

    assign at_end = ({1'b0, r_idx} == CntW'(r_cnt - 1'b1));
    assign we     = (r_state == rsor_pkg::B_IDLE) && i_pop_valid
                    && (r_cnt != CntW'(MAX_POINTS));

    rsor_ram #(.WIDTH(DistW), .DEPTH(MAX_POINTS)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (r_cnt[AW-1:0]),
        .i_wdata (i_pop_word.distance),
        .i_raddr (r_idx),
        .o_rdata (rdata)
    );

    // one divider for the mean and the variance
    assign div_dividend = (r_state == rsor_pkg::B_MEAN_GO) ? VarW'(r_sum) : r_sq;
    assign div_divisor  = (r_state == rsor_pkg::B_MEAN_GO) ? r_cnt : CntW'(r_cnt - 1'b1);

    rsor_div #(.W(VarW), .DW(CntW)) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_done     (div_done),
        .o_quo      (div_quo)
    );

    rsor_isqrt #(.W(VarW)) u_isqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (root_start),
        .i_value (div_quo),
        .o_done  (root_done),
        .o_root  (root)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rsor_pkg::B_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == rsor_pkg::B_IDLE && i_pop_valid && we) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (r_state == rsor_pkg::B_OUT_CMP) begin
                r_valid <= 1'b1;
            end else if (r_state == rsor_pkg::B_OUT_WT && i_ready) begin
                r_valid <= 1'b0;
                if (r_last) r_cnt <= '0;
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        unique case (r_state)
            rsor_pkg::B_IDLE: begin
                r_idx <= '0;
                r_sum <= '0;
                r_sq  <= '0;
            end
            rsor_pkg::B_SUM_AC: begin
                r_sum <= r_sum + SumW'(rdata);
                r_idx <= at_end ? '0 : r_idx + 1'b1;
            end
            rsor_pkg::B_MEAN_WT: begin
                if (div_done) r_mean <= div_quo[DistW-1:0];
            end
            rsor_pkg::B_VAR_DF: begin
                r_df <= (rdata >= r_mean) ? rdata - r_mean : r_mean - rdata;
            end
            rsor_pkg::B_VAR_MUL: r_prod <= r_df * r_df;
            rsor_pkg::B_VAR_AC: begin
                r_sq    <= r_sq + VarW'(r_prod);
                r_idx   <= at_end ? '0 : r_idx + 1'b1;
                r_sigma <= '0;
            end
            rsor_pkg::B_ROOT_WT: begin
                if (root_done) r_sigma <= root;
            end
            rsor_pkg::B_LIM: begin
                r_lim <= LimW'({r_mean, FB'(0)})
                         + LimW'(i_cfg.sigma_mult) * LimW'(r_sigma);
            end
            rsor_pkg::B_OUT_CMP: begin
                r_keep <= !i_cfg.reject_en || (LimW'({rdata, FB'(0)}) < r_lim);
                r_last <= at_end;
            end
            rsor_pkg::B_OUT_WT: begin
                if (i_ready && !r_last) r_idx <= r_idx + 1'b1;
            end
            default: begin
            end
        endcase
    end

    // evaluation sequencer
    always_comb begin
        n_state     = r_state;
        o_pop_ready = 1'b0;
        div_start   = 1'b0;
        root_start  = 1'b0;
        unique case (r_state)
            rsor_pkg::B_IDLE: begin
                o_pop_ready = 1'b1;
                if (i_pop_valid && i_pop_word.eos) n_state = rsor_pkg::B_SUM_RD;
            end
            rsor_pkg::B_SUM_RD: n_state = rsor_pkg::B_SUM_AC;
            rsor_pkg::B_SUM_AC: n_state = at_end ? rsor_pkg::B_MEAN_GO : rsor_pkg::B_SUM_RD;
            rsor_pkg::B_MEAN_GO: begin
                div_start = 1'b1;
                n_state   = rsor_pkg::B_MEAN_WT;
            end
            rsor_pkg::B_MEAN_WT: begin
                if (div_done) n_state = rsor_pkg::B_VAR_RD;
            end
            rsor_pkg::B_VAR_RD:  n_state = rsor_pkg::B_VAR_DF;
            rsor_pkg::B_VAR_DF:  n_state = rsor_pkg::B_VAR_MUL;
            rsor_pkg::B_VAR_MUL: n_state = rsor_pkg::B_VAR_AC;
            rsor_pkg::B_VAR_AC: begin
                if (!at_end) begin
                    n_state = rsor_pkg::B_VAR_RD;
                end else if (r_cnt == CntW'(1)) begin
                    n_state = rsor_pkg::B_LIM;
                end else begin
                    n_state = rsor_pkg::B_DVAR_GO;
                end
            end
            rsor_pkg::B_DVAR_GO: begin
                div_start = 1'b1;
                n_state   = rsor_pkg::B_DVAR_WT;
            end
            rsor_pkg::B_DVAR_WT: begin
                if (div_done) n_state = rsor_pkg::B_ROOT_GO;
            end
            rsor_pkg::B_ROOT_GO: begin
                root_start = 1'b1;
                n_state    = rsor_pkg::B_ROOT_WT;
            end
            rsor_pkg::B_ROOT_WT: begin
                if (root_done) n_state = rsor_pkg::B_LIM;
            end
            rsor_pkg::B_LIM:     n_state = rsor_pkg::B_OUT_RD;
            rsor_pkg::B_OUT_RD:  n_state = rsor_pkg::B_OUT_CMP;
            rsor_pkg::B_OUT_CMP: n_state = rsor_pkg::B_OUT_WT;
            rsor_pkg::B_OUT_WT: begin
                if (i_ready) n_state = r_last ? rsor_pkg::B_IDLE : rsor_pkg::B_OUT_RD;
            end
            default: n_state = rsor_pkg::B_IDLE;
        endcase
    end

    assign o_valid       = r_valid;
    assign o_pair_index  = rsor_pkg::OutIdxW'(r_idx);
    assign o_keep        = r_keep;
    assign o_last_result = r_last;
endmodule
`default_nettype wire

// ----- sv/range_sigma_outlier_reject.sv -----
// range_sigma_outlier_reject: top level, front end, word queue, back end, config.
// Depends on rsor_pkg, rsor_front, rsor_fifo and rsor_back.
//
//  channel | signals                                  | direction
//  input   | i_valid/o_ready, i_p_x..i_q_y, i_end_of_set | in
//  result  | o_valid/i_ready, o_pair_index, o_keep, o_last_result | out
//  config  | i_cfg_valid/o_cfg_ready, i_cfg_index, i_cfg_data | in
//
// Front end: one pair at a time (square, add, 25-step distance square root, push).
// A four-word queue lets the front keep loading while the back end evaluates.
// Evaluation on the last pair: sum, divide (mean), variance, divide, root
// (divide and root skipped for a single pair), then one result word at a time,
// held under any output stall. Reset is synchronous, active low; no clearing pass.
`default_nettype none
module range_sigma_outlier_reject #(
    parameter int MAX_POINTS = rsor_pkg::MaxPoints
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    output logic                               o_ready,
    input  wire logic [rsor_pkg::CoordW-1:0]   i_p_x,
    input  wire logic [rsor_pkg::CoordW-1:0]   i_p_y,
    input  wire logic [rsor_pkg::CoordW-1:0]   i_q_x,
    input  wire logic [rsor_pkg::CoordW-1:0]   i_q_y,
    input  wire logic                          i_end_of_set,
    output logic                               o_valid,
    input  wire logic                          i_ready,
    output logic [rsor_pkg::OutIdxW-1:0]       o_pair_index,
    output logic                               o_keep,
    output logic                               o_last_result,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic                          i_cfg_index,
    input  wire logic [rsor_pkg::MultW-1:0]    i_cfg_data
);
    rsor_pkg::t_cfg       r_cfg;
    rsor_pkg::t_dist_word push_word, pop_word;
    logic push_valid, push_ready, pop_valid, pop_ready;

    // configuration registers
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.reject_en  <= 1'b0;
            r_cfg.sigma_mult <= rsor_pkg::SigmaMultReset;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                rsor_pkg::CfgIdxRejectEnable: r_cfg.reject_en  <= i_cfg_data[0];
                rsor_pkg::CfgIdxSigmaMult:    r_cfg.sigma_mult <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    rsor_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_p_x        (i_p_x),
        .i_p_y        (i_p_y),
        .i_q_x        (i_q_x),
        .i_q_y        (i_q_y),
        .i_end_of_set (i_end_of_set),
        .o_push_valid (push_valid),
        .i_push_ready (push_ready),
        .o_push_word  (push_word)
    );

    rsor_fifo u_fifo (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push_valid (push_valid),
        .o_push_ready (push_ready),
        .i_push_word  (push_word),
        .o_pop_valid  (pop_valid),
        .i_pop_ready  (pop_ready),
        .o_pop_word   (pop_word)
    );

    rsor_back #(.MAX_POINTS(MAX_POINTS)) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_pop_valid   (pop_valid),
        .o_pop_ready   (pop_ready),
        .i_pop_word    (pop_word),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_pair_index  (o_pair_index),
        .o_keep        (o_keep),
        .o_last_result (o_last_result)
    );
endmodule
`default_nettype wire

// ----- sv/rsor_checker.sv -----
// rsor_checker: port level checks on the result channel, bound to the top level.
// Depends on range_sigma_outlier_reject.
`default_nettype none
module rsor_checker (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       o_valid,
    input wire logic       i_ready,
    input wire logic [5:0] o_pair_index,
    input wire logic       o_keep,
    input wire logic       o_last_result
);
    // stalled result word holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_pair_index)
            && $stable(o_keep) && $stable(o_last_result))
        else $error("result word changed under stall");

    // each result word is fetched anew: a gap follows every taken word
    a_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_ready |=> !o_valid)
        else $error("result word not followed by a gap");

    // no result straight out of reset
    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");
endmodule

bind range_sigma_outlier_reject rsor_checker u_rsor_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_valid       (o_valid),
    .i_ready       (i_ready),
    .o_pair_index  (o_pair_index),
    .o_keep        (o_keep),
    .o_last_result (o_last_result)
);
`default_nettype wire

// ----- test/range_sigma_outlier_reject_chk.sv -----
// Checker for range_sigma_outlier_reject: watches input, config and result channels,
// predicts per-pair keep decisions and compares them. Depends on rsor_pkg.
`default_nettype none
module range_sigma_outlier_reject_chk (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_valid,
    input  wire logic                        i_ready_in,
    input  wire logic [rsor_pkg::CoordW-1:0] i_p_x,
    input  wire logic [rsor_pkg::CoordW-1:0] i_p_y,
    input  wire logic [rsor_pkg::CoordW-1:0] i_q_x,
    input  wire logic [rsor_pkg::CoordW-1:0] i_q_y,
    input  wire logic                        i_end_of_set,
    input  wire logic                        i_res_valid,
    input  wire logic                        i_res_ready,
    input  wire logic [rsor_pkg::OutIdxW-1:0] i_pair_index,
    input  wire logic                        i_keep,
    input  wire logic                        i_last_result,
    input  wire logic                        i_cfg_valid,
    input  wire logic                        i_cfg_ready,
    input  wire logic                        i_cfg_index,
    input  wire logic [rsor_pkg::MultW-1:0]  i_cfg_data,
    output int                               o_fail_count,
    output int                               o_pending
);
    import rsor_pkg::*;

    typedef struct packed {
        logic [OutIdxW-1:0] idx;
        logic               keep;
        logic               last;
    } t_verdict;

    t_verdict              verdict_q[$];
    logic [DistW-1:0]      dist_mem[MaxPoints];
    int                    n_loaded;
    logic                  rej_en;
    logic [MultW-1:0]      k_mult;

    assign o_pending = verdict_q.size();

    // floor square root, bit by bit
    function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // distance of one pair, stored; on set end emit verdicts
    task automatic load_pair(input logic [CoordW-1:0] px, input logic [CoordW-1:0] py,
                             input logic [CoordW-1:0] qx, input logic [CoordW-1:0] qy,
                             input logic eos);
        longint     dx;
        longint     dy;
        logic [63:0] sum;
        logic [63:0] sq;
        logic [63:0] mean;
        logic [63:0] sig;
        logic [63:0] lim;
        logic [63:0] df;
        t_verdict   v;
        dx = longint'($signed(px)) - longint'($signed(qx));
        dy = longint'($signed(py)) - longint'($signed(qy));
        if (dx < 0) dx = -dx;
        if (dy < 0) dy = -dy;
        if (n_loaded < MaxPoints) begin
            dist_mem[n_loaded] = DistW'(floor_sqrt(64'(dx * dx + dy * dy)));
            n_loaded++;
        end
        if (!eos) return;
        sum = 0;
        sq = 0;
        sig = 0;
        for (int i = 0; i < n_loaded; i++) sum += dist_mem[i];
        mean = sum / n_loaded;
        for (int i = 0; i < n_loaded; i++) begin
            df = (dist_mem[i] >= mean) ? dist_mem[i] - mean : mean - dist_mem[i];
            sq += df * df;
        end
        if (n_loaded > 1) sig = floor_sqrt(sq / (n_loaded - 1));
        lim = (mean << FracBits) + 64'(k_mult) * sig;
        for (int i = 0; i < n_loaded; i++) begin
            v.idx  = OutIdxW'(i);
            v.keep = rej_en ? ((64'(dist_mem[i]) << FracBits) < lim) : 1'b1;
            v.last = (i == n_loaded - 1);
            verdict_q.insert(verdict_q.size(), v);
        end
        n_loaded = 0;
    endtask

    // sample all channels at the rising edge
    always @(posedge i_clk) begin
        t_verdict want;
        if (!i_rst_n) begin
            verdict_q.delete();
            n_loaded     = 0;
            rej_en       = 1'b0;
            k_mult       = SigmaMultReset;
            o_fail_count = 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == CfgIdxRejectEnable) rej_en = i_cfg_data[0];
                else k_mult = i_cfg_data;
            end
            if (i_valid && i_ready_in)
                load_pair(i_p_x, i_p_y, i_q_x, i_q_y, i_end_of_set);
            if (i_res_valid && i_res_ready) begin
                if (verdict_q.size() == 0) begin
                    o_fail_count++;
                    if (o_fail_count <= 10)
                        $display("unexpected result word idx=%0d keep=%0b last=%0b",
                                 i_pair_index, i_keep, i_last_result);
                end else begin
                    want = verdict_q.pop_front();
                    if (want.idx !== i_pair_index || want.keep !== i_keep
                        || want.last !== i_last_result) begin
                        o_fail_count++;
                        if (o_fail_count <= 10)
                            $display("mismatch: exp idx=%0d keep=%0b last=%0b, got %0d %0b %0b",
                                     want.idx, want.keep, want.last,
                                     i_pair_index, i_keep, i_last_result);
                    end
                end
            end
        end
    end
endmodule
`default_nettype wire

// ----- test/range_sigma_outlier_reject_tb.sv -----
// Testbench top for range_sigma_outlier_reject: clock, reset, stimulus and verdict.
// Depends on rsor_pkg, the block and range_sigma_outlier_reject_chk.
`default_nettype none
module range_sigma_outlier_reject_tb;
    import rsor_pkg::*;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [CoordW-1:0]   p_x, p_y, q_x, q_y;
    logic                eos;
    logic                res_valid;
    logic                res_ready;
    logic [OutIdxW-1:0]  pair_index;
    logic                keep;
    logic                last_result;
    logic                cfg_valid;
    logic                cfg_ready;
    logic                cfg_index;
    logic [MultW-1:0]    cfg_data;
    int                  fail_count;
    int                  pending;
    int                  cycles;
    int                  burst_left;
    int                  stall_mode;

    localparam int CycleLimit = 3_000_000;

    range_sigma_outlier_reject i_dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .o_ready(in_ready),
        .i_p_x(p_x), .i_p_y(p_y), .i_q_x(q_x), .i_q_y(q_y), .i_end_of_set(eos),
        .o_valid(res_valid), .i_ready(res_ready),
        .o_pair_index(pair_index), .o_keep(keep), .o_last_result(last_result),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    range_sigma_outlier_reject_chk i_chk (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_valid(in_valid), .i_ready_in(in_ready),
        .i_p_x(p_x), .i_p_y(p_y), .i_q_x(q_x), .i_q_y(q_y), .i_end_of_set(eos),
        .i_res_valid(res_valid), .i_res_ready(res_ready),
        .i_pair_index(pair_index), .i_keep(keep), .i_last_result(last_result),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial clk = 1'b0;
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // watchdog
    initial cycles = 0;
    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles == CycleLimit) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // receiver stall pattern: phases of always ready, random, and heavy stall
    initial stall_mode = 0;
    always @(negedge clk) begin
        if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: res_ready <= 1'b1;
            1: res_ready <= ($urandom_range(0, 1) == 1);
            default: res_ready <= ($urandom_range(0, 7) == 0);
        endcase
    end

    // one word on the input channel, with bursty sender gaps
    task automatic send_pair(input logic [CoordW-1:0] ax, input logic [CoordW-1:0] ay,
                             input logic [CoordW-1:0] bx, input logic [CoordW-1:0] by,
                             input logic last);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            repeat ($urandom_range(0, 40)) @(negedge clk);
        end
        // valid was dropped at an earlier falling edge
        @(negedge clk);
        burst_left--;
        in_valid <= 1'b1;
        p_x <= ax; p_y <= ay; q_x <= bx; q_y <= by; eos <= last;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic idx, input logic [MultW-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // let the block drain; extra cycles cover a front end still busy
    task automatic drain;
        while (pending != 0) @(negedge clk);
        repeat (200) @(negedge clk);
    endtask

    // random coordinate: mostly clustered, sometimes full-range
    function automatic logic [CoordW-1:0] rand_coord();
        if ($urandom_range(0, 5) == 0) return CoordW'($urandom);
        return CoordW'($signed($urandom_range(0, 4095)) - 2048);
    endfunction

    task automatic random_set(input int n);
        for (int i = 0; i < n; i++)
            send_pair(rand_coord(), rand_coord(), rand_coord(), rand_coord(), i == n - 1);
    endtask

    localparam logic [CoordW-1:0] CMax = 24'h7FFFFF;
    localparam logic [CoordW-1:0] CMin = 24'h800000;

    initial begin
        rst_n = 1'b0;
        in_valid = 1'b0; cfg_valid = 1'b0; cfg_index = 1'b0; cfg_data = '0;
        p_x = '0; p_y = '0; q_x = '0; q_y = '0; eos = 1'b0;
        res_ready = 1'b1;
        burst_left = 0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: defaults keep everything; single pair; extremes
        send_pair(CMax, CMax, CMin, CMin, 1'b1);
        drain();
        write_reg(CfgIdxRejectEnable, 12'd1);
        send_pair(24'd100, 24'd0, 24'd0, 24'd0, 1'b1);
        send_pair(CMin, CMax, CMax, CMin, 1'b0);
        send_pair(24'd0, 24'd0, 24'd0, 24'd0, 1'b0);
        send_pair(24'd256, 24'd0, 24'd0, 24'd0, 1'b0);
        send_pair(CMax, 24'd0, CMin, 24'd0, 1'b1);
        // equal distances: sigma zero, none kept at threshold
        send_pair(24'd5, 24'd5, 24'd5, 24'd5, 1'b0);
        send_pair(24'd5, 24'd5, 24'd5, 24'd5, 1'b1);
        drain();
        write_reg(CfgIdxSigmaMult, 12'd0);
        send_pair(24'd10, 24'd0, 24'd0, 24'd0, 1'b0);
        send_pair(24'd30, 24'd0, 24'd0, 24'd0, 1'b1);
        drain();
        write_reg(CfgIdxSigmaMult, 12'hFFF);
        random_set(3);
        // overflow of the store: 66 pairs, last 2 dropped
        drain();
        write_reg(CfgIdxSigmaMult, 12'd256);
        random_set(66);
        drain();

        // random phases across settings
        for (int ph = 0; ph < 8; ph++) begin
            write_reg(CfgIdxRejectEnable, 12'($urandom_range(0, 1)));
            write_reg(CfgIdxSigmaMult, (ph == 0) ? 12'd0 : (ph == 1) ? 12'hFFF
                                                : 12'($urandom_range(0, 4095)));
            repeat (4) random_set($urandom_range(1, 8));
            if (ph == 3) random_set(MaxPoints);
            drain();
        end

        while (pending != 0) @(negedge clk);
        repeat (300) @(negedge clk);
        if (fail_count == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end
endmodule
`default_nettype wire

// ----- sim.f -----
sv/rsor_pkg.sv
sv/rsor_ram.sv
sv/rsor_isqrt.sv
sv/rsor_div.sv
sv/rsor_fifo.sv
sv/rsor_front.sv
sv/rsor_back.sv
sv/range_sigma_outlier_reject.sv
sv/rsor_checker.sv
test/range_sigma_outlier_reject_chk.sv
test/range_sigma_outlier_reject_tb.sv
